// ===== hw/rtl/dle_stx_etx_frame_receiver_core_macros.svh =====
// Assertion helpers shared by the frame receiver modules.
`ifndef DLE_STX_ETX_FRAME_RECEIVER_CORE_MACROS_SVH
`define DLE_STX_ETX_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DSER_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("dser: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DSER_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("dser: next-cycle check failed");

`endif

// ===== hw/rtl/dser_pkg.sv =====
// ----------------------------------------------------------------------------
// dser_pkg
// Shared types and constants of the DLE/STX/ETX frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dser_pkg;

    localparam logic [7:0] CH_DLE = 8'h10;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;

    localparam int FIXED_LEN_W = 7;
    localparam int TRL_COUNT_W = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIXED_LENGTH  = 1'b0,
        REG_TRAILER_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_RX         = 2'd0,
        KIND_RD_PAYLOAD = 2'd1,
        KIND_RD_TRAILER = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_WAIT_DLE  = 3'd0,
        PH_WAIT_STX  = 3'd1,
        PH_DATA      = 3'd2,
        PH_AFTER_DLE = 3'd3,
        PH_WAIT_ETX  = 3'd4,
        PH_TRAILER   = 3'd5
    } phase_t;

    // Per-beat result info passed from the control stage to the output pipe.
    typedef struct packed {
        logic       done;
        logic [7:0] payload_length;
        logic       rd_payload;
        logic       rd_valid;
    } dser_meta_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dser_mem.sv =====
// ----------------------------------------------------------------------------
// dser_mem
// Single-port-write, single-port-read byte RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dser_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dser_ctrl.sv =====
// ----------------------------------------------------------------------------
// dser_ctrl
// Framing state machine, counters and config registers; drives the buffer
// writes and read requests for each accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dle_stx_etx_frame_receiver_core_macros.svh"

module dser_ctrl #(
    parameter int MAX_LEN     = 128,
    parameter int MAX_TRAILER = 8,
    parameter int PAW         = 7,
    parameter int TAW         = 3
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [dser_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dser_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             accept,
    input  wire logic [1:0]                       kind,
    input  wire logic [7:0]                       rx_byte,
    input  wire logic [6:0]                       read_index,
    output dser_pkg::dser_meta_t                  meta,
    output logic                                  pay_we,
    output logic [PAW-1:0]                        pay_waddr,
    output logic [7:0]                            pay_wdata,
    output logic                                  pay_re,
    output logic [PAW-1:0]                        pay_raddr,
    output logic                                  trl_we,
    output logic [TAW-1:0]                        trl_waddr,
    output logic [7:0]                            trl_wdata,
    output logic                                  trl_re,
    output logic [TAW-1:0]                        trl_raddr
);

    import dser_pkg::*;

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int TW     = $clog2(MAX_TRAILER + 1);
    localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
    localparam int TCMP_W = (TW > TRL_COUNT_W) ? TW : TRL_COUNT_W;
    localparam int RP_W   = (CNT_W > 7) ? CNT_W : 7;
    localparam int RT_W   = (TW > 7) ? TW : 7;

    phase_t                  phase_reg, phase_next, phase_cur;
    logic [CNT_W-1:0]        count_reg, count_next, count_cur;
    logic [TW-1:0]           fill_reg, fill_next;
    logic [FIXED_LEN_W-1:0]  fixed_len_reg;
    logic [TRL_COUNT_W-1:0]  trl_count_reg;

    logic                    guard;
    logic [CMP_W-1:0]        count_x, fixed_x, count_cur_x, len_x;
    logic [TCMP_W-1:0]       trl_x, target_x, fill_after_x;
    logic [TW-1:0]           fill_after;
    logic [RP_W-1:0]         idx_p;
    logic [RT_W-1:0]         idx_t;
    logic                    done;
    logic                    eof;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_len_reg <= '0;
            trl_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIXED_LENGTH:  fixed_len_reg <= cfg_data[FIXED_LEN_W-1:0];
                REG_TRAILER_COUNT: trl_count_reg <= cfg_data[TRL_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_DLE;
            count_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

    // Overflow guard, applied before every received byte
    always_comb
    begin
        count_x  = CMP_W'(count_reg);
        fixed_x  = CMP_W'(fixed_len_reg);
        guard    = ((fixed_len_reg != '0) && (count_x > (fixed_x + CMP_W'(1))))
                   || (count_reg >= CNT_W'(MAX_LEN));
        phase_cur   = guard ? PH_WAIT_DLE : phase_reg;
        count_cur   = guard ? '0 : count_reg;
        count_cur_x = CMP_W'(count_cur);
        trl_x       = TCMP_W'(trl_count_reg);
        target_x    = (trl_x > TCMP_W'(MAX_TRAILER)) ? TCMP_W'(MAX_TRAILER) : trl_x;
        idx_p       = RP_W'(read_index);
        idx_t       = RT_W'(read_index);
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        fill_after = fill_reg;
        fill_after_x = '0;
        done       = 1'b0;
        eof        = 1'b0;
        pay_we     = 1'b0;
        pay_waddr  = count_cur[PAW-1:0];
        pay_wdata  = rx_byte;
        pay_re     = 1'b0;
        pay_raddr  = idx_p[PAW-1:0];
        trl_we     = 1'b0;
        trl_waddr  = fill_reg[TAW-1:0];
        trl_wdata  = rx_byte;
        trl_re     = 1'b0;
        trl_raddr  = idx_t[TAW-1:0];
        meta.rd_payload = 1'b0;
        meta.rd_valid   = 1'b0;

        if (accept)
        begin
            case (kind)
                KIND_RX:
                begin
                    phase_next = phase_cur;
                    count_next = count_cur;
                    case (phase_cur)
                        PH_WAIT_DLE:
                        begin
                            if (rx_byte == CH_DLE)
                            begin
                                phase_next = PH_WAIT_STX;
                            end
                        end
                        PH_WAIT_STX:
                        begin
                            if (rx_byte == CH_STX)
                            begin
                                phase_next = PH_DATA;
                                count_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_WAIT_DLE;
                            end
                        end
                        PH_DATA:
                        begin
                            // guard keeps count_cur below MAX_LEN here
                            pay_we     = 1'b1;
                            count_next = count_cur + CNT_W'(1);
                            if (rx_byte == CH_DLE)
                            begin
                                if (fixed_len_reg == '0)
                                begin
                                    phase_next = PH_AFTER_DLE;
                                end
                                else if (count_cur_x == fixed_x)
                                begin
                                    phase_next = PH_WAIT_ETX;
                                end
                            end
                        end
                        PH_AFTER_DLE:
                        begin
                            if (rx_byte == CH_DLE)
                            begin
                                phase_next = PH_DATA;
                            end
                            else if (rx_byte == CH_ETX)
                            begin
                                eof = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_WAIT_DLE;
                            end
                        end
                        PH_WAIT_ETX:
                        begin
                            if (rx_byte == CH_ETX)
                            begin
                                eof = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_WAIT_DLE;
                            end
                        end
                        PH_TRAILER:
                        begin
                            if (fill_reg < TW'(MAX_TRAILER))
                            begin
                                trl_we     = 1'b1;
                                fill_after = fill_reg + TW'(1);
                            end
                            fill_next    = fill_after;
                            fill_after_x = TCMP_W'(fill_after);
                            if (fill_after_x >= target_x)
                            begin
                                phase_next = PH_WAIT_DLE;
                                done       = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_WAIT_DLE;
                        end
                    endcase

                    // DLE ETX: drop the stored DLE, then trailer or done
                    if (eof)
                    begin
                        count_next = (count_cur != '0) ? (count_cur - CNT_W'(1)) : count_cur;
                        fill_next  = '0;
                        if (target_x != '0)
                        begin
                            phase_next = PH_TRAILER;
                        end
                        else
                        begin
                            phase_next = PH_WAIT_DLE;
                            done       = 1'b1;
                        end
                    end
                end
                KIND_RD_PAYLOAD:
                begin
                    meta.rd_payload = 1'b1;
                    meta.rd_valid   = (idx_p < RP_W'(count_reg)) && (idx_p < RP_W'(MAX_LEN));
                    pay_re          = meta.rd_valid;
                end
                KIND_RD_TRAILER:
                begin
                    meta.rd_valid = (idx_t < RT_W'(fill_reg)) && (idx_t < RT_W'(MAX_TRAILER));
                    trl_re        = meta.rd_valid;
                end
                default: ;
            endcase
        end

        len_x               = CMP_W'(count_next);
        meta.done           = done;
        meta.payload_length = len_x[7:0];
    end

    `DSER_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, (count_reg <= CNT_W'(MAX_LEN)))
    `DSER_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, (fill_reg <= TW'(MAX_TRAILER)))
    `DSER_ASSERT_NEXT(a_done_idle, clk, rst_n, (accept && done), (phase_reg == PH_WAIT_DLE))

endmodule

`default_nettype wire

// ===== hw/rtl/dser_out.sv =====
// ----------------------------------------------------------------------------
// dser_out
// Two-entry result pipe: a read-data stage aligned with the buffer RAMs and
// an output register, so a new beat is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dle_stx_etx_frame_receiver_core_macros.svh"

module dser_out (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  dser_pkg::dser_meta_t       meta,
    input  wire logic [7:0]            pay_rdata,
    input  wire logic [7:0]            trl_rdata,
    input  wire logic                  result_stall,
    output logic                       busy,
    output logic                       result_valid,
    output logic                       frame_done,
    output logic [7:0]                 payload_length,
    output logic [7:0]                 read_value,
    output logic                       read_valid
);

    import dser_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    dser_meta_t s1_meta_reg;
    logic       s2_valid_reg, s2_valid_next;
    logic       done_reg, rd_valid_reg;
    logic [7:0] len_reg, value_reg;
    logic       s1_move;
    logic [7:0] s1_value;

    assign s1_move       = s1_valid_reg && (!s2_valid_reg || !result_stall);
    assign busy          = s1_valid_reg && !s1_move;
    assign s1_valid_next = accept || (s1_valid_reg && !s1_move);
    assign s2_valid_next = s1_move || (s2_valid_reg && result_stall);

    always_comb
    begin
        if (!s1_meta_reg.rd_valid)
        begin
            s1_value = 8'h00;
        end
        else if (s1_meta_reg.rd_payload)
        begin
            s1_value = pay_rdata;
        end
        else
        begin
            s1_value = trl_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_move)
        begin
            done_reg     <= s1_meta_reg.done;
            len_reg      <= s1_meta_reg.payload_length;
            value_reg    <= s1_value;
            rd_valid_reg <= s1_meta_reg.rd_valid;
        end
    end

    assign result_valid   = s2_valid_reg;
    assign frame_done     = done_reg;
    assign payload_length = len_reg;
    assign read_value     = value_reg;
    assign read_valid     = rd_valid_reg;

    `DSER_ASSERT_NOW(a_busy_full, clk, rst_n, busy, (s2_valid_reg && s1_valid_reg))
    `DSER_ASSERT_NOW(a_no_accept_busy, clk, rst_n, busy, !accept)
    `DSER_ASSERT_NEXT(a_s1_hold, clk, rst_n, busy, ($stable(s1_meta_reg) && s1_valid_reg))

endmodule

`default_nettype wire

// ===== hw/rtl/dle_stx_etx_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// dle_stx_etx_frame_receiver_core
// DLE STX ... DLE ETX framed byte receiver with trailer capture and
// indexed read-back of payload and trailer bytes.
// ----------------------------------------------------------------------------
// Takes one beat per clock while item_stall is low: a received line byte or
// a read of a stored payload/trailer byte. Each beat gives exactly one result
// beat; the framing state and counters update in the accept cycle, the
// payload and trailer RAMs are written in that cycle and give registered read
// data, and the result then lands in an output register.
// Two results can be held, so item_stall rises only when the output is
// stalled and both stages are full. The RAMs need no clearing pass after
// reset. cfg_ready is always high; write config only while idle.
`default_nettype none

module dle_stx_etx_frame_receiver_core #(
    parameter int MAX_LEN     = 128,
    parameter int MAX_TRAILER = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dser_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dser_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire logic [1:0]                       kind,
    input  wire logic [7:0]                       rx_byte,
    input  wire logic [6:0]                       read_index,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic                                  frame_done,
    output logic [7:0]                            payload_length,
    output logic [7:0]                            read_value,
    output logic                                  read_valid
);

    import dser_pkg::*;

    localparam int PAW = $clog2(MAX_LEN);
    localparam int TAW = (MAX_TRAILER > 1) ? $clog2(MAX_TRAILER) : 1;

    logic           accept;
    dser_meta_t     meta;
    logic           pay_we, pay_re, trl_we, trl_re;
    logic [PAW-1:0] pay_waddr, pay_raddr;
    logic [TAW-1:0] trl_waddr, trl_raddr;
    logic [7:0]     pay_wdata, trl_wdata, pay_rdata, trl_rdata;

    assign cfg_ready = 1'b1;
    assign accept    = item_valid && !item_stall;

    dser_ctrl #(
        .MAX_LEN     (MAX_LEN),
        .MAX_TRAILER (MAX_TRAILER),
        .PAW         (PAW),
        .TAW         (TAW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .kind       (kind),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .meta       (meta),
        .pay_we     (pay_we),
        .pay_waddr  (pay_waddr),
        .pay_wdata  (pay_wdata),
        .pay_re     (pay_re),
        .pay_raddr  (pay_raddr),
        .trl_we     (trl_we),
        .trl_waddr  (trl_waddr),
        .trl_wdata  (trl_wdata),
        .trl_re     (trl_re),
        .trl_raddr  (trl_raddr)
    );

    dser_mem #(
        .DEPTH (MAX_LEN),
        .AW    (PAW)
    ) u_pay_mem (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    dser_mem #(
        .DEPTH (MAX_TRAILER),
        .AW    (TAW)
    ) u_trl_mem (
        .clk   (clk),
        .we    (trl_we),
        .waddr (trl_waddr),
        .wdata (trl_wdata),
        .re    (trl_re),
        .raddr (trl_raddr),
        .rdata (trl_rdata)
    );

    dser_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .meta           (meta),
        .pay_rdata      (pay_rdata),
        .trl_rdata      (trl_rdata),
        .result_stall   (result_stall),
        .busy           (item_stall),
        .result_valid   (result_valid),
        .frame_done     (frame_done),
        .payload_length (payload_length),
        .read_value     (read_value),
        .read_valid     (read_valid)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for dle_stx_etx_frame_receiver_core. Drives framed byte streams,
// payload and trailer reads under varying source gaps and sink stalls. A
// behavioral predictor tracks the framing state and both stores, and every
// result beat is compared against it in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dser_pkg::*;

    localparam int MAX_LEN      = 128;
    localparam int MAX_TRAILER  = 8;
    localparam int SETTLE       = 4;
    localparam int STUCK_LIMIT  = 2000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic       done;
        logic [7:0] plen;
        logic [7:0] rval;
        logic       rvalid;
    } rx_result_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_FIXED_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    logic [1:0]            kind         = KIND_RX;
    logic [7:0]            rx_byte      = 8'h00;
    logic [6:0]            read_index   = 7'd0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  frame_done;
    logic [7:0]            payload_length;
    logic [7:0]            read_value;
    logic                  read_valid;

    // predictor state
    int         fix_len;
    int         trl_cnt;
    phase_t     rx_ph;
    logic [7:0] pl_mem [MAX_LEN];
    int         pl_count;
    logic [7:0] tr_mem [MAX_TRAILER];
    int         tr_fill;

    rx_result_t rx_result_q [$];
    rx_result_t head_r;
    int         n_errors       = 0;
    int         beats_sent     = 0;
    int         stuck_cycles   = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;

    dle_stx_etx_frame_receiver_core #(
        .MAX_LEN     (MAX_LEN),
        .MAX_TRAILER (MAX_TRAILER)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .read_index     (read_index),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .frame_done     (frame_done),
        .payload_length (payload_length),
        .read_value     (read_value),
        .read_valid     (read_valid)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int trailer_goal();
        return (trl_cnt > MAX_TRAILER) ? MAX_TRAILER : trl_cnt;
    endfunction

    // DLE ETX seen: drop the stored DLE, then trailer or done
    function automatic bit close_frame();
        if (pl_count > 0)
            pl_count--;
        tr_fill = 0;
        if (trailer_goal() > 0)
        begin
            rx_ph = PH_TRAILER;
            return 1'b0;
        end
        rx_ph = PH_WAIT_DLE;
        return 1'b1;
    endfunction

    function automatic bit take_line_byte(input logic [7:0] b);
        bit done;
        done = 1'b0;
        // overflow guard runs ahead of every line byte
        if ((fix_len != 0 && pl_count > fix_len + 1) || pl_count >= MAX_LEN)
        begin
            pl_count = 0;
            rx_ph    = PH_WAIT_DLE;
        end
        case (rx_ph)
            PH_WAIT_DLE:
                if (b == CH_DLE)
                    rx_ph = PH_WAIT_STX;
            PH_WAIT_STX:
                if (b == CH_STX)
                begin
                    rx_ph    = PH_DATA;
                    pl_count = 0;
                end
                else
                    rx_ph = PH_WAIT_DLE;
            PH_DATA:
            begin
                if (pl_count < MAX_LEN)
                begin
                    pl_mem[pl_count] = b;
                    pl_count++;
                end
                if (b == CH_DLE)
                begin
                    if (fix_len == 0)
                        rx_ph = PH_AFTER_DLE;
                    else if (pl_count - 1 == fix_len)
                        rx_ph = PH_WAIT_ETX;
                end
            end
            PH_AFTER_DLE:
                if (b == CH_DLE)
                    rx_ph = PH_DATA;
                else if (b == CH_ETX)
                    done = close_frame();
                else
                    rx_ph = PH_WAIT_DLE;
            PH_WAIT_ETX:
                if (b == CH_ETX)
                    done = close_frame();
                else
                    rx_ph = PH_WAIT_DLE;
            PH_TRAILER:
            begin
                if (tr_fill < MAX_TRAILER)
                begin
                    tr_mem[tr_fill] = b;
                    tr_fill++;
                end
                if (tr_fill >= trailer_goal())
                begin
                    rx_ph = PH_WAIT_DLE;
                    done  = 1'b1;
                end
            end
            default:
                rx_ph = PH_WAIT_DLE;
        endcase
        return done;
    endfunction

    function automatic rx_result_t step_receiver(input logic [1:0] k, input logic [7:0] b,
                                                 input logic [6:0] idx);
        rx_result_t r;
        r.done   = 1'b0;
        r.rval   = 8'h00;
        r.rvalid = 1'b0;
        if (k == KIND_RX)
            r.done = take_line_byte(b);
        else if (k == KIND_RD_PAYLOAD)
        begin
            if (int'(idx) < pl_count)
            begin
                r.rval   = pl_mem[idx];
                r.rvalid = 1'b1;
            end
        end
        else if (k == KIND_RD_TRAILER)
        begin
            if (int'(idx) < tr_fill && int'(idx) < MAX_TRAILER)
            begin
                r.rval   = tr_mem[idx];
                r.rvalid = 1'b1;
            end
        end
        r.plen = 8'(pl_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sink, checker, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < sink_stall_pct);

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (rx_result_q.size() == 0)
            begin
                $display("%0t: unexpected result beat: done=%0d len=%0d val=%0d vld=%0d",
                         $time, frame_done, payload_length, read_value, read_valid);
                n_errors++;
            end
            else
            begin
                head_r = rx_result_q.pop_front();
                check_field("frame_done", 8'(head_r.done), 8'(frame_done));
                check_field("payload_length", head_r.plen, payload_length);
                check_field("read_value", head_r.rval, read_value);
                check_field("read_valid", 8'(head_r.rvalid), 8'(read_valid));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: watchdog: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] k, input logic [7:0] b, input logic [6:0] idx);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        rx_byte    <= b;
        read_index <= idx;
        rx_result_q.push_back(step_receiver(k, b, idx));
        if (k != KIND_UNUSED)
            beats_sent++;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_beat(KIND_RX, b, 7'($urandom));
    endtask

    // hold off until every result is back and the pipe is empty
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (rx_result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == REG_FIXED_LENGTH)
            fix_len = data;
        else
            trl_cnt = data[3:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [6:0] fix, input logic [3:0] trl);
        wait_idle();
        cfg_write(REG_FIXED_LENGTH, fix);
        cfg_write(REG_TRAILER_COUNT, {3'($urandom), trl});
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(3))
            0:       return CH_DLE;
            1:       return CH_STX;
            2:       return CH_ETX;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_read();
        logic [1:0] k;
        int         top;
        k   = $urandom_range(1) ? KIND_RD_PAYLOAD : KIND_RD_TRAILER;
        top = (k == KIND_RD_PAYLOAD) ? pl_count + 1 : MAX_TRAILER + 1;
        if (top > 127)
            top = 127;
        send_beat(k, 8'($urandom),
                  ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(top)));
    endtask

    // one frame with random content; some are deliberately malformed
    task automatic send_frame();
        int         len;
        int         n_trl;
        logic [7:0] b;
        send_rx(CH_DLE);
        send_rx(CH_STX);
        if (fix_len == 0)
            len = ($urandom_range(15) == 0) ? $urandom_range(130, 122) : $urandom_range(12);
        else
        begin
            len = fix_len;
            if ($urandom_range(4) == 0)
                len = len + $urandom_range(5) - 2;
            if (len < 0)
                len = 0;
        end
        for (int i = 0; i < len; i++)
        begin
            b = ($urandom_range(7) == 0) ? CH_DLE : 8'($urandom);
            send_rx(b);
            if (fix_len == 0 && b == CH_DLE)
                send_rx(CH_DLE);
        end
        send_rx(CH_DLE);
        if (fix_len == 0 && $urandom_range(9) == 0)
            send_rx(noise_byte());
        else
            send_rx(CH_ETX);
        n_trl = trailer_goal();
        if ($urandom_range(5) == 0)
            n_trl = $urandom_range(n_trl + 2);
        repeat (n_trl) send_rx(8'($urandom));
        repeat ($urandom_range(4, 1)) send_read();
    endtask

    task automatic run_segment(input int n);
        int start;
        int pick;
        start = beats_sent;
        while (beats_sent - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame();
            else if (pick < 85)
                repeat ($urandom_range(6, 1)) send_rx(noise_byte());
            else if (pick < 95)
                send_read();
            else if (pick < 98)
                send_beat(KIND_UNUSED, 8'($urandom), 7'($urandom));
            else
                wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_variable_frames();
        // doubled DLE stands for one data DLE
        send_rx(CH_DLE);
        send_rx(CH_STX);
        send_rx(8'h00);
        send_rx(CH_DLE);
        send_rx(CH_DLE);
        send_rx(8'hFF);
        send_rx(CH_DLE);
        send_rx(CH_ETX);
        send_beat(KIND_RD_PAYLOAD, 8'hFF, 7'd1);
        send_beat(KIND_RD_PAYLOAD, 8'h00, 7'd3);
        send_beat(KIND_RD_PAYLOAD, 8'h00, 7'd127);
        send_beat(KIND_RD_TRAILER, 8'h00, 7'd0);
        send_beat(KIND_UNUSED, 8'hFF, 7'd127);
        // DLE then a stray byte aborts; partial payload stays readable
        send_rx(CH_DLE);
        send_rx(CH_STX);
        send_rx(8'h55);
        send_rx(CH_DLE);
        send_rx(8'h41);
        send_beat(KIND_RD_PAYLOAD, 8'h00, 7'd0);
    endtask

    task automatic test_fixed_frames();
        set_config(7'd2, 4'd4);
        // DLE and ETX inside a fixed payload are plain data
        send_rx(CH_DLE);
        send_rx(CH_STX);
        send_rx(CH_DLE);
        send_rx(CH_ETX);
        send_rx(CH_DLE);
        send_rx(CH_ETX);
        send_rx(8'hAA);
        send_rx(8'hBB);
        // shrink the trailer count mid-trailer: next byte completes the frame
        wait_idle();
        cfg_write(REG_TRAILER_COUNT, 7'd1);
        send_rx(8'hCC);
        send_beat(KIND_RD_TRAILER, 8'h00, 7'd2);
        send_beat(KIND_RD_PAYLOAD, 8'h00, 7'd1);
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 67;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 67;
                end
                default:
                begin
                    src_idle_pct   = 38;
                    sink_stall_pct = 38;
                end
            endcase
            case (seg)
                0:       set_config(7'd0, 4'd0);
                1:       set_config(7'd0, 4'd8);
                2:       set_config(7'd1, 4'd15);
                3:       set_config(7'($urandom_range(24, 2)), 4'($urandom));
                4:       set_config(7'd126, 4'd2);
                5:       set_config(7'd0, 4'($urandom));
                6:       set_config(7'd127, 4'd1);
                default: set_config(7'($urandom_range(24, 2)), 4'd0);
            endcase
            run_segment(175);
        end
    endtask

    initial
    begin
        fix_len  = 0;
        trl_cnt  = 0;
        rx_ph    = PH_WAIT_DLE;
        pl_count = 0;
        tr_fill  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_variable_frames();
        test_fixed_frames();
        test_random_traffic();
        wait_idle();
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
